// ----- rtl/pws_pkg.sv -----
package pws_pkg;

   localparam int MAX_MOTIF = 32;

   localparam int ACTION_W = 2;
   localparam int BYTE_W   = 8;
   localparam int ROW_W    = 5;
   localparam int BASE_W   = 2;
   localparam int WEIGHT_W = 16;
   localparam int CODE_W   = 3;
   localparam int SCORE_W  = 21;
   localparam int POS_W    = 32;
   localparam int MLEN_W   = 6;

   // window length counter holds 0..MAX_MOTIF, cell index 0..MAX_MOTIF-1
   localparam int RUN_W = $clog2(MAX_MOTIF + 1);
   localparam int IDX_W = (MAX_MOTIF > 1) ? $clog2(MAX_MOTIF) : 1;

   localparam logic [ACTION_W-1:0] ACT_SEQ     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WEIGHT  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TABLE   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd3;

   localparam logic [CODE_W-1:0] CODE_INVALID = 3'd4;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOTIF_LEN = 1'b1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   // queue fill plus the two pipeline stages ahead of it
   localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 3);

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   typedef struct packed {
      logic              shift;
      logic              clear;
      logic [BASE_W-1:0] code;
   } pws_ctl_type;

   typedef struct packed {
      logic                       wr_en;
      logic [BASE_W-1:0]          base;
      logic signed [WEIGHT_W-1:0] value;
   } pws_wload_type;

   typedef struct packed {
      logic [POS_W-1:0]          start_position;
      logic signed [SCORE_W-1:0] score;
   } pws_rsp_type;

   function automatic logic signed [SCORE_W-1:0] sat_add(
      input logic signed [SCORE_W-1:0]  a,
      input logic signed [WEIGHT_W-1:0] b
   );
      logic signed [SCORE_W:0] s;
      s = {a[SCORE_W-1], a} + {{(SCORE_W+1-WEIGHT_W){b[WEIGHT_W-1]}}, b};
      if (s[SCORE_W] != s[SCORE_W-1]) begin
         sat_add = s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end else begin
         sat_add = s[SCORE_W-1:0];
      end
   endfunction

endpackage

// ----- rtl/pws_cell.sv -----
module pws_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  pws_pkg::pws_ctl_type                ctl,
   input  pws_pkg::pws_wload_type              wload,
   input  logic signed [pws_pkg::SCORE_W-1:0]  sum_prev,
   output logic signed [pws_pkg::SCORE_W-1:0]  sum_out
);

   logic signed [pws_pkg::WEIGHT_W-1:0] weight_ff [4];
   logic signed [pws_pkg::SCORE_W-1:0]  sum_ff;
   logic signed [pws_pkg::SCORE_W-1:0]  sum_in;

   always_comb begin
      sum_in = sum_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.shift) begin
         sum_in = pws_pkg::sat_add(sum_prev, weight_ff[ctl.code]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wload.wr_en) begin
         weight_ff[wload.base] <= wload.value;
      end
   end

   assign sum_out = sum_ff;

endmodule

// ----- rtl/pws_base_table.sv -----
module pws_base_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [pws_pkg::BYTE_W-1:0]        wr_addr,
   input  logic [pws_pkg::CODE_W-1:0]        wr_code,
   input  logic                              rd_en,
   input  logic [pws_pkg::BYTE_W-1:0]        rd_addr,
   output logic [pws_pkg::CODE_W-1:0]        rd_code
);

   localparam int DEPTH = 2 ** pws_pkg::BYTE_W;

   logic [pws_pkg::CODE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]           vld_ff;
   logic [pws_pkg::CODE_W-1:0] code_ff;
   logic                       hit_ff;
   logic [pws_pkg::CODE_W-1:0] wr_code_clip;

   // codes above the invalid code are stored as invalid
   assign wr_code_clip = (wr_code > pws_pkg::CODE_INVALID) ? pws_pkg::CODE_INVALID : wr_code;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_code_clip;
      end
      if (rd_en) begin
         code_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_code = hit_ff ? code_ff : pws_pkg::CODE_INVALID;

endmodule

// ----- rtl/pws_out_fifo.sv -----
module pws_out_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  pws_pkg::pws_rsp_type          push_data,
   input  logic                          pop,
   output logic                          out_valid,
   output pws_pkg::pws_rsp_type          out_data,
   output logic [pws_pkg::FIFO_CW-1:0]   count
);

   pws_pkg::pws_rsp_type              mem [pws_pkg::FIFO_DEPTH];
   logic [pws_pkg::FIFO_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pws_pkg::FIFO_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pws_pkg::FIFO_CW-1:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == pws_pkg::FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == pws_pkg::FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign count     = cnt_ff;

endmodule

// ----- rtl/pssm_window_scan.sv -----
// Position weight matrix scanner for DNA byte streams. One item is accepted
// per clock cycle while req_stall is low; a chain of MAX_MOTIF cells (one
// per motif row, each holding its four weights and one running window sum)
// advances by one valid sequence byte at a time. A match passes through the
// byte-to-base table read, the cell chain update, and window selection and
// threshold compare into a four-entry result queue, held there while
// rsp_stall is high. req_stall rises only when that queue, counting the
// items still in the pipeline, could not take another result. The byte table
// keeps a valid bit per entry, so it reads as invalid right after reset with
// no clearing pass. Configuration must be written while the block is idle.
module pssm_window_scan (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pws_pkg::ACTION_W-1:0]          req_action,
   input  logic [pws_pkg::BYTE_W-1:0]            req_seq_byte,
   input  logic [pws_pkg::ROW_W-1:0]             req_weight_row,
   input  logic [pws_pkg::BASE_W-1:0]            req_weight_base,
   input  logic signed [pws_pkg::WEIGHT_W-1:0]   req_weight_value,
   input  logic [pws_pkg::BYTE_W-1:0]            req_table_byte,
   input  logic [pws_pkg::CODE_W-1:0]            req_table_code,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pws_pkg::POS_W-1:0]             rsp_start_position,
   output logic signed [pws_pkg::SCORE_W-1:0]    rsp_score,

   input  logic                                  csr_write,
   input  logic [pws_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pws_pkg::SCORE_W-1:0]           csr_wdata
);

   logic accept;

   // configuration
   logic signed [pws_pkg::SCORE_W-1:0] thr_ff;
   logic [pws_pkg::MLEN_W-1:0]         mlen_ff;
   logic [pws_pkg::RUN_W-1:0]          len;
   logic [pws_pkg::IDX_W-1:0]          len_m1;
   logic [pws_pkg::POS_W-1:0]          len_m1_pos;

   // stage 1: table lookup
   logic                               s1_vld_ff;
   logic [pws_pkg::ACTION_W-1:0]       s1_act_ff;
   logic [pws_pkg::ROW_W-1:0]          s1_row_ff;
   logic [pws_pkg::BASE_W-1:0]         s1_base_ff;
   logic signed [pws_pkg::WEIGHT_W-1:0] s1_wval_ff;
   logic [pws_pkg::CODE_W-1:0]         s1_code;
   logic                               s1_is_seq;
   logic                               s1_byte_ok;
   logic                               s1_restart;
   pws_pkg::pws_ctl_type               cell_ctl;

   // stage 2: window bookkeeping
   logic [pws_pkg::RUN_W-1:0]          run_ff, run_in;
   logic [pws_pkg::POS_W-1:0]          bcnt_ff, bcnt_in;
   logic                               s2_cand_ff, s2_cand_in;
   logic [pws_pkg::POS_W-1:0]          s2_start_ff, s2_start_in;

   logic signed [pws_pkg::SCORE_W-1:0] psum [pws_pkg::MAX_MOTIF];
   logic signed [pws_pkg::SCORE_W-1:0] win_score;

   logic                               push;
   pws_pkg::pws_rsp_type               push_data;
   pws_pkg::pws_rsp_type               out_data;
   logic                               pop;
   logic [pws_pkg::FIFO_CW-1:0]        fifo_cnt;
   logic [pws_pkg::CREDIT_W-1:0]       credit;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= '0;
         mlen_ff <= pws_pkg::MLEN_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            pws_pkg::CSR_THRESHOLD: thr_ff  <= csr_wdata;
            pws_pkg::CSR_MOTIF_LEN: mlen_ff <= csr_wdata[pws_pkg::MLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (mlen_ff == '0) begin
         len = pws_pkg::RUN_W'(1);
      end else if (int'(mlen_ff) > pws_pkg::MAX_MOTIF) begin
         len = pws_pkg::RUN_W'(pws_pkg::MAX_MOTIF);
      end else begin
         len = pws_pkg::RUN_W'(mlen_ff);
      end
   end

   assign len_m1     = pws_pkg::IDX_W'(len - 1'b1);
   assign len_m1_pos = pws_pkg::POS_W'(len) - 1'b1;

   // ---------------------------------------------------------------- input
   // items in flight that may still yield a result hold a queue slot
   assign credit    = pws_pkg::CREDIT_W'(fifo_cnt) + pws_pkg::CREDIT_W'(s1_vld_ff)
                    + pws_pkg::CREDIT_W'(s2_cand_ff);
   assign req_stall = (int'(credit) >= pws_pkg::FIFO_DEPTH);
   assign accept    = req_valid && !req_stall;

   pws_base_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && (req_action == pws_pkg::ACT_TABLE)),
      .wr_addr (req_table_byte),
      .wr_code (req_table_code),
      .rd_en   (accept),
      .rd_addr (req_seq_byte),
      .rd_code (s1_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff  <= req_action;
         s1_row_ff  <= req_weight_row;
         s1_base_ff <= req_weight_base;
         s1_wval_ff <= req_weight_value;
      end
   end

   // ---------------------------------------------------------------- cells
   assign s1_is_seq  = s1_vld_ff && (s1_act_ff == pws_pkg::ACT_SEQ);
   assign s1_byte_ok = s1_is_seq && (s1_code < pws_pkg::CODE_INVALID);
   assign s1_restart = s1_vld_ff && (s1_act_ff == pws_pkg::ACT_RESTART);

   assign cell_ctl.shift = s1_byte_ok;
   assign cell_ctl.clear = s1_restart || (s1_is_seq && !s1_byte_ok);
   assign cell_ctl.code  = s1_code[pws_pkg::BASE_W-1:0];

   for (genvar k = 0; k < pws_pkg::MAX_MOTIF; k++) begin : g_cell
      pws_pkg::pws_wload_type               wload;
      logic signed [pws_pkg::SCORE_W-1:0]   sum_prev;

      assign wload.wr_en = s1_vld_ff && (s1_act_ff == pws_pkg::ACT_WEIGHT)
                        && (int'(s1_row_ff) == k);
      assign wload.base  = s1_base_ff;
      assign wload.value = s1_wval_ff;

      if (k == 0) begin : g_head
         assign sum_prev = '0;
      end else begin : g_link
         assign sum_prev = psum[k-1];
      end

      pws_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .wload    (wload),
         .sum_prev (sum_prev),
         .sum_out  (psum[k])
      );
   end

   // ---------------------------------------------------------------- window
   always_comb begin
      run_in      = run_ff;
      bcnt_in     = bcnt_ff;
      s2_cand_in  = 1'b0;
      s2_start_in = (bcnt_ff >= len_m1_pos) ? bcnt_ff - len_m1_pos : '0;
      if (s1_restart) begin
         run_in  = '0;
         bcnt_in = '0;
      end else if (s1_is_seq) begin
         if (bcnt_ff != '1) begin
            bcnt_in = bcnt_ff + 1'b1;
         end
         if (s1_byte_ok) begin
            if (int'(run_ff) != pws_pkg::MAX_MOTIF) begin
               run_in = run_ff + 1'b1;
            end
            s2_cand_in = (run_in >= len);
         end else begin
            run_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= '0;
         bcnt_ff    <= '0;
         s2_cand_ff <= 1'b0;
      end else begin
         run_ff     <= run_in;
         bcnt_ff    <= bcnt_in;
         s2_cand_ff <= s2_cand_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_start_ff <= s2_start_in;
   end

   // ---------------------------------------------------------------- result
   assign win_score = psum[len_m1];
   assign push      = s2_cand_ff && (win_score >= thr_ff);

   assign push_data.start_position = s2_start_ff;
   assign push_data.score          = win_score;

   assign pop = rsp_valid && !rsp_stall;

   pws_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .count     (fifo_cnt)
   );

   assign rsp_start_position = out_data.start_position;
   assign rsp_score          = out_data.score;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      int'(credit) <= pws_pkg::FIFO_DEPTH)
      else $error("result queue credit overrun");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (int'(fifo_cnt) < pws_pkg::FIFO_DEPTH || pop))
      else $error("push into full result queue");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      s1_restart |=> (run_ff == '0 && bcnt_ff == '0 && psum[0] == '0 && !s2_cand_ff))
      else $error("restart did not clear window");

   a_bad_byte_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_is_seq && !s1_byte_ok) |=> (run_ff == '0 && !s2_cand_ff))
      else $error("invalid byte did not clear window");
`endif

endmodule

// ----- dv/pssm_match_checker.sv -----
`timescale 1ns / 1ps

module pssm_match_checker (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [pws_pkg::ACTION_W-1:0]         req_action,
   input  logic [pws_pkg::BYTE_W-1:0]           req_seq_byte,
   input  logic [pws_pkg::ROW_W-1:0]            req_weight_row,
   input  logic [pws_pkg::BASE_W-1:0]           req_weight_base,
   input  logic signed [pws_pkg::WEIGHT_W-1:0]  req_weight_value,
   input  logic [pws_pkg::BYTE_W-1:0]           req_table_byte,
   input  logic [pws_pkg::CODE_W-1:0]           req_table_code,

   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [pws_pkg::POS_W-1:0]            rsp_start_position,
   input  logic signed [pws_pkg::SCORE_W-1:0]   rsp_score,

   input  logic                                 csr_write,
   input  logic [pws_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pws_pkg::SCORE_W-1:0]          csr_wdata,

   output int                                   pending,
   output int                                   fail_count
);

   typedef struct {
      logic [pws_pkg::POS_W-1:0]          start;
      logic signed [pws_pkg::SCORE_W-1:0] score;
   } match_type;

   // shadow copy of the scanner state
   logic signed [pws_pkg::WEIGHT_W-1:0] weight_mem [pws_pkg::MAX_MOTIF*4];
   logic [pws_pkg::CODE_W-1:0]          code_mem [256];
   logic signed [pws_pkg::SCORE_W-1:0]  cell_sum [pws_pkg::MAX_MOTIF];
   int unsigned                         run_len;
   logic [pws_pkg::POS_W-1:0]           seq_count;
   logic signed [pws_pkg::SCORE_W-1:0]  thr;
   logic [pws_pkg::MLEN_W-1:0]          mlen;

   match_type expected_matches [$];
   int        errors;

   function automatic logic signed [pws_pkg::SCORE_W-1:0] clamp_score(input longint v);
      if (v > longint'(pws_pkg::SCORE_MAX)) return pws_pkg::SCORE_MAX;
      if (v < longint'(pws_pkg::SCORE_MIN)) return pws_pkg::SCORE_MIN;
      return v[pws_pkg::SCORE_W-1:0];
   endfunction

   task automatic clear_window();
      int k;
      for (k = 0; k < pws_pkg::MAX_MOTIF; k++) cell_sum[k] = '0;
      run_len = 0;
   endtask

   task automatic scan_item();
      logic [pws_pkg::CODE_W-1:0] code;
      logic [pws_pkg::POS_W-1:0]  pos;
      int unsigned                len;
      int                         k;
      match_type                  m;
      case (req_action)
         pws_pkg::ACT_WEIGHT: begin
            weight_mem[{req_weight_row, req_weight_base}] = req_weight_value;
         end
         pws_pkg::ACT_TABLE: begin
            code_mem[req_table_byte] = (req_table_code > pws_pkg::CODE_INVALID) ?
                                       pws_pkg::CODE_INVALID : req_table_code;
         end
         pws_pkg::ACT_RESTART: begin
            clear_window();
            seq_count = '0;
         end
         pws_pkg::ACT_SEQ: begin
            pos  = seq_count;
            code = code_mem[req_seq_byte];
            if (mlen == '0) begin
               len = 1;
            end else if (int'(mlen) > pws_pkg::MAX_MOTIF) begin
               len = pws_pkg::MAX_MOTIF;
            end else begin
               len = int'(mlen);
            end
            if (seq_count != '1) seq_count = seq_count + 1'b1;
            if (code >= pws_pkg::CODE_INVALID) begin
               clear_window();
            end else begin
               // shift from the top so each cell sees the previous byte's sum
               for (k = pws_pkg::MAX_MOTIF - 1; k >= 1; k--) begin
                  cell_sum[k] = clamp_score(longint'(cell_sum[k-1]) +
                                            longint'(weight_mem[k*4 + code[1:0]]));
               end
               cell_sum[0] = weight_mem[code[1:0]];
               if (run_len < pws_pkg::MAX_MOTIF) run_len++;
               if (run_len >= len && cell_sum[len-1] >= thr) begin
                  m.start = (pos >= pws_pkg::POS_W'(len - 1)) ?
                            pos - pws_pkg::POS_W'(len - 1) : '0;
                  m.score = cell_sum[len-1];
                  expected_matches.push_back(m);
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      match_type m;
      int        k;
      if (reset) begin
         for (k = 0; k < pws_pkg::MAX_MOTIF*4; k++) weight_mem[k] = '0;
         for (k = 0; k < 256; k++) code_mem[k] = pws_pkg::CODE_INVALID;
         clear_window();
         seq_count = '0;
         thr       = '0;
         mlen      = pws_pkg::MLEN_W'(1);
         expected_matches.delete();
         errors    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_matches.size() == 0) begin
               $display("%0t unexpected match: expected none, actual start %0d score %0d",
                        $time, rsp_start_position, rsp_score);
               errors++;
            end else begin
               m = expected_matches.pop_front();
               if (rsp_start_position !== m.start) begin
                  $display("%0t start_position mismatch: expected %0d, actual %0d",
                           $time, m.start, rsp_start_position);
                  errors++;
               end
               if (rsp_score !== m.score) begin
                  $display("%0t score mismatch: expected %0d, actual %0d",
                           $time, m.score, rsp_score);
                  errors++;
               end
            end
         end
         if (csr_write) begin
            if (csr_index == pws_pkg::CSR_THRESHOLD) thr = csr_wdata;
            else if (csr_index == pws_pkg::CSR_MOTIF_LEN) mlen = csr_wdata[pws_pkg::MLEN_W-1:0];
         end
         if (req_valid && !req_stall) scan_item();
      end
      pending    <= expected_matches.size();
      fail_count <= errors;
   end

endmodule

// ----- dv/tb_pssm_window_scan.sv -----
`timescale 1ns / 1ps

module tb_pssm_window_scan;

   localparam int ITEM_COUNT = 1050;

   typedef struct {
      logic [pws_pkg::ACTION_W-1:0]        action;
      logic [pws_pkg::BYTE_W-1:0]          seq_byte;
      logic [pws_pkg::ROW_W-1:0]           weight_row;
      logic [pws_pkg::BASE_W-1:0]          weight_base;
      logic signed [pws_pkg::WEIGHT_W-1:0] weight_value;
      logic [pws_pkg::BYTE_W-1:0]          table_byte;
      logic [pws_pkg::CODE_W-1:0]          table_code;
   } scan_req_type;

   typedef enum {RX_FREE, RX_RANDOM, RX_HEAVY} rx_mode_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [pws_pkg::ACTION_W-1:0]        req_action = '0;
   logic [pws_pkg::BYTE_W-1:0]          req_seq_byte = '0;
   logic [pws_pkg::ROW_W-1:0]           req_weight_row = '0;
   logic [pws_pkg::BASE_W-1:0]          req_weight_base = '0;
   logic signed [pws_pkg::WEIGHT_W-1:0] req_weight_value = '0;
   logic [pws_pkg::BYTE_W-1:0]          req_table_byte = '0;
   logic [pws_pkg::CODE_W-1:0]          req_table_code = '0;

   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [pws_pkg::POS_W-1:0]           rsp_start_position;
   logic signed [pws_pkg::SCORE_W-1:0]  rsp_score;

   logic                                csr_write = 1'b0;
   logic [pws_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [pws_pkg::SCORE_W-1:0]         csr_wdata = '0;

   int          pending;
   int          fail_count;
   int unsigned burst_left = 0;
   int unsigned n_sent = 0;
   rx_mode_type rx_mode = RX_FREE;
   int unsigned rx_left = 0;

   // A C G T a c g t; letter i maps to base i % 4
   logic [7:0] letters [8] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h61, 8'h63, 8'h67, 8'h74};

   pssm_window_scan DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_seq_byte       (req_seq_byte),
      .req_weight_row     (req_weight_row),
      .req_weight_base    (req_weight_base),
      .req_weight_value   (req_weight_value),
      .req_table_byte     (req_table_byte),
      .req_table_code     (req_table_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_start_position (rsp_start_position),
      .rsp_score          (rsp_score),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   pssm_match_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_seq_byte       (req_seq_byte),
      .req_weight_row     (req_weight_row),
      .req_weight_base    (req_weight_base),
      .req_weight_value   (req_weight_value),
      .req_table_byte     (req_table_byte),
      .req_table_code     (req_table_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_start_position (rsp_start_position),
      .rsp_score          (rsp_score),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .pending            (pending),
      .fail_count         (fail_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver: free-running, random and heavy stall stretches
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(4, 60);
      end
      rx_left = rx_left - 1;
      case (rx_mode)
         RX_FREE:   rsp_stall <= 1'b0;
         RX_RANDOM: rsp_stall <= ($urandom_range(0, 1) == 1);
         default:   rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   // fields the action does not use still carry random values
   function automatic scan_req_type noise_req();
      scan_req_type r;
      r.action       = pws_pkg::ACTION_W'($urandom_range(0, 3));
      r.seq_byte     = pws_pkg::BYTE_W'($urandom);
      r.weight_row   = pws_pkg::ROW_W'($urandom);
      r.weight_base  = pws_pkg::BASE_W'($urandom);
      r.weight_value = pws_pkg::WEIGHT_W'($urandom);
      r.table_byte   = pws_pkg::BYTE_W'($urandom);
      r.table_code   = pws_pkg::CODE_W'($urandom);
      return r;
   endfunction

   task automatic push_item(input scan_req_type r);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left = burst_left - 1;
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_seq_byte     <= r.seq_byte;
      req_weight_row   <= r.weight_row;
      req_weight_base  <= r.weight_base;
      req_weight_value <= r.weight_value;
      req_table_byte   <= r.table_byte;
      req_table_code   <= r.table_code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
   endtask

   task automatic send_seq(input logic [pws_pkg::BYTE_W-1:0] b);
      scan_req_type r;
      r = noise_req();
      r.action   = pws_pkg::ACT_SEQ;
      r.seq_byte = b;
      push_item(r);
   endtask

   task automatic send_weight(input logic [pws_pkg::ROW_W-1:0] row,
                              input logic [pws_pkg::BASE_W-1:0] base,
                              input logic [pws_pkg::WEIGHT_W-1:0] value);
      scan_req_type r;
      r = noise_req();
      r.action       = pws_pkg::ACT_WEIGHT;
      r.weight_row   = row;
      r.weight_base  = base;
      r.weight_value = value;
      push_item(r);
   endtask

   task automatic send_table(input logic [pws_pkg::BYTE_W-1:0] b,
                             input logic [pws_pkg::CODE_W-1:0] code);
      scan_req_type r;
      r = noise_req();
      r.action     = pws_pkg::ACT_TABLE;
      r.table_byte = b;
      r.table_code = code;
      push_item(r);
   endtask

   task automatic send_restart();
      scan_req_type r;
      r = noise_req();
      r.action = pws_pkg::ACT_RESTART;
      push_item(r);
   endtask

   // hold off until every match is out and the pipeline has drained
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_config(input logic [pws_pkg::SCORE_W-1:0] thr_word,
                             input logic [pws_pkg::SCORE_W-1:0] len_word);
      csr_write <= 1'b1;
      csr_index <= pws_pkg::CSR_THRESHOLD;
      csr_wdata <= thr_word;
      @(posedge clock);
      csr_index <= pws_pkg::CSR_MOTIF_LEN;
      csr_wdata <= len_word;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int unsigned                        k, j, roll, noise_pct, len_eff, phase_len;
      logic [pws_pkg::MLEN_W-1:0]         ml;
      logic signed [pws_pkg::SCORE_W-1:0] thr;
      logic [pws_pkg::WEIGHT_W-1:0]       wv;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // byte table reads invalid straight out of reset
      send_seq(8'h41);
      send_seq(8'h00);
      send_seq(8'hff);
      send_restart();

      for (k = 0; k < 8; k++) send_table(letters[k], pws_pkg::CODE_W'(k % 4));
      send_table(8'h4e, pws_pkg::CODE_INVALID);
      // codes above the invalid code fold to invalid
      send_table(8'h00, 3'd5);
      send_table(8'h80, 3'd6);
      send_table(8'hff, 3'd7);

      // every weight is written before the first valid byte
      for (k = 0; k < pws_pkg::MAX_MOTIF * 4; k++) begin
         case ($urandom_range(0, 7))
            0:       wv = 16'h7fff;
            1:       wv = 16'h8000;
            default: wv = pws_pkg::WEIGHT_W'($urandom);
         endcase
         send_weight(pws_pkg::ROW_W'(k / 4), pws_pkg::BASE_W'(k % 4), wv);
      end

      // reset settings: threshold 0, length 1
      send_seq(8'h41);
      send_seq(8'h43);
      send_seq(8'h47);
      send_seq(8'h54);
      send_seq(8'h00);
      send_seq(8'h61);
      send_seq(8'h4e);
      send_seq(8'h80);
      send_seq(8'h67);
      send_restart();
      send_seq(8'h74);

      // length zero behaves as one
      wait_idle();
      set_config(pws_pkg::SCORE_MIN, pws_pkg::SCORE_W'({$urandom, 6'd0}));
      send_seq(8'h54);
      send_seq(8'h41);
      send_seq(8'h63);

      wait_idle();
      set_config(pws_pkg::SCORE_MAX, pws_pkg::SCORE_W'({$urandom, 6'd3}));
      send_seq(8'h41);
      send_seq(8'h43);
      send_seq(8'h47);
      send_seq(8'h54);

      while (n_sent < ITEM_COUNT) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       ml = 6'd0;
            1:       ml = 6'd63;
            2:       ml = 6'd32;
            3:       ml = pws_pkg::MLEN_W'($urandom_range(33, 63));
            4, 5:    ml = pws_pkg::MLEN_W'($urandom_range(1, 32));
            default: ml = pws_pkg::MLEN_W'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 7))
            0:       thr = pws_pkg::SCORE_MIN;
            1:       thr = pws_pkg::SCORE_MAX;
            2:       thr = '0;
            3:       thr = pws_pkg::SCORE_W'($urandom);
            default: thr = pws_pkg::SCORE_W'(int'($urandom_range(0, 60000)) - 30000);
         endcase
         // upper bits of the length word are don't-care
         set_config(thr, pws_pkg::SCORE_W'({$urandom, ml}));

         if (ml == '0) begin
            len_eff = 1;
         end else if (int'(ml) > pws_pkg::MAX_MOTIF) begin
            len_eff = pws_pkg::MAX_MOTIF;
         end else begin
            len_eff = int'(ml);
         end
         // long motifs need long valid runs to match at all
         noise_pct = (len_eff > 8) ? 1 : 8;
         phase_len = (len_eff > 8) ? $urandom_range(100, 160) : $urandom_range(40, 120);

         for (j = 0; j < phase_len && n_sent < ITEM_COUNT; j++) begin
            roll = $urandom_range(0, 99);
            if (roll < noise_pct) begin
               send_seq(pws_pkg::BYTE_W'($urandom));
            end else if (roll < noise_pct + 3) begin
               send_weight(pws_pkg::ROW_W'($urandom), pws_pkg::BASE_W'($urandom),
                           pws_pkg::WEIGHT_W'($urandom));
            end else if (roll < noise_pct + 6) begin
               if ($urandom_range(0, 1) == 1) begin
                  send_table(letters[$urandom_range(0, 7)],
                             pws_pkg::CODE_W'($urandom_range(0, 3)));
               end else begin
                  send_table(pws_pkg::BYTE_W'($urandom),
                             pws_pkg::CODE_W'($urandom_range(0, 7)));
               end
            end else if (roll < noise_pct + 7) begin
               send_restart();
            end else if (roll < noise_pct + 8) begin
               wait_idle();
            end else begin
               send_seq(letters[$urandom_range(0, 7)]);
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
